// File: rtl/lbph_pkg.sv
// Shared types, codes and constants of the 3x3 LBP histogram block.
`timescale 1ns / 1ps
`default_nettype none
package lbph_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COUNT_BITS = 24;
    localparam int DEF_CHANNELS   = 3;

    // Fixed widths of the interface.
    localparam int SAMPLE_BITS    = 8;
    localparam int CODE_BITS      = 8;
    localparam int BIN_NUM        = 256;
    localparam int OUT_COUNT_BITS = 24;
    localparam int MAX_CHANNELS   = 3;
    localparam int FW_BITS        = 11;
    localparam int FH_BITS        = 13;
    localparam int ADDR_BITS      = 4;
    localparam int DATA_BITS      = 32;

    localparam logic [OUT_COUNT_BITS-1:0] OUT_COUNT_MAX = {OUT_COUNT_BITS{1'b1}};
    localparam logic [FW_BITS-1:0]        FW_RESET      = 11'd1024;
    localparam logic [FH_BITS-1:0]        FH_RESET      = 13'd1024;
    localparam int                        MIN_SIZE      = 3;

    // Operation codes of an input word.
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    typedef enum logic [1:0] {
        JOB_BUMP,
        JOB_READ,
        JOB_CLEAR
    } t_job_kind;

    // An accepted word as it enters the window stage.
    typedef struct packed {
        logic                 valid;
        logic [1:0]           op;
        logic                 win_ok;
        logic [1:0]           nch;
        logic [CODE_BITS-1:0] bin;
    } t_acc;

    // Work handed to the histogram unit; a read carries its bin in codes[0].
    typedef struct packed {
        logic                                    valid;
        t_job_kind                               kind;
        logic [1:0]                              count;
        logic [MAX_CHANNELS-1:0][CODE_BITS-1:0]  codes;
    } t_job;

    typedef struct packed {
        logic free_after;
    } t_hist_status;

endpackage
`default_nettype wire

// File: rtl/lbph_window.sv
// Line stores, 3x3 window registers and LBP code generation.
`timescale 1ns / 1ps
`default_nettype none
module lbph_window #(
    parameter int MAX_WIDTH = lbph_pkg::DEF_MAX_WIDTH,
    parameter int CHANNELS  = lbph_pkg::DEF_CHANNELS
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  lbph_pkg::t_acc                         i_acc,
    input  wire [$clog2(MAX_WIDTH)-1:0]            i_acc_col,
    input  wire [lbph_pkg::SAMPLE_BITS*CHANNELS-1:0] i_acc_pix,
    output lbph_pkg::t_job                         o_job,
    output logic                                   o_s1_busy
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SB = lbph_pkg::SAMPLE_BITS;
    localparam int PW = SB * CHANNELS;

    logic [PW-1:0] line_near [MAX_WIDTH];
    logic [PW-1:0] line_far  [MAX_WIDTH];

    logic [PW-1:0]  r_top;
    logic [PW-1:0]  r_mid;
    logic           r_s1_valid;
    lbph_pkg::t_acc r_s1;
    logic [CW-1:0]  r_s1_col;
    logic [PW-1:0]  r_s1_pix;
    logic [PW-1:0]  r_win [6];

    logic           s0_push;
    logic           s1_push;
    logic [PW-1:0]  nb [8];
    logic [lbph_pkg::MAX_CHANNELS-1:0][lbph_pkg::CODE_BITS-1:0] codes;

    assign s0_push = i_acc.valid && (i_acc.op == lbph_pkg::OP_PUSH);
    assign s1_push = r_s1_valid && (r_s1.op == lbph_pkg::OP_PUSH);

    // Near line store: read at the new column, written with the pixel in the following cycle.
    always_ff @(posedge i_clk) begin
        if (s1_push) begin
            line_near[r_s1_col] <= r_s1_pix;
        end
        if (s0_push) begin
            r_mid <= line_near[i_acc_col];
        end
    end

    // Far line store: takes over the word that leaves the near store.
    always_ff @(posedge i_clk) begin
        if (s1_push) begin
            line_far[r_s1_col] <= r_mid;
        end
        if (s0_push) begin
            r_top <= line_far[i_acc_col];
        end
    end

    // Stage one control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_acc.valid;
        end
    end

    // Stage one payload.
    always_ff @(posedge i_clk) begin
        if (i_acc.valid) begin
            r_s1     <= i_acc;
            r_s1_col <= i_acc_col;
            r_s1_pix <= i_acc_pix;
        end
    end

    // Window registers shift left by one column on every pushed pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_push) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= r_top;
            r_win[4] <= r_mid;
            r_win[5] <= r_s1_pix;
        end
    end

    // Neighbours in code order, most significant bit first.
    always_comb begin
        nb[0] = r_win[0];
        nb[1] = r_win[1];
        nb[2] = r_win[2];
        nb[3] = r_win[3];
        nb[4] = r_win[5];
        nb[5] = r_top;
        nb[6] = r_mid;
        nb[7] = r_s1_pix;
    end

    // One comparison per neighbour and channel against the centre.
    always_comb begin
        codes = '0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            for (int i = 0; i < 8; i++) begin
                codes[ch][7-i] = nb[i][SB*ch +: SB] > r_win[4][SB*ch +: SB];
            end
        end
    end

    // Build the job for the histogram unit.
    always_comb begin
        o_job          = '0;
        o_job.kind     = lbph_pkg::JOB_BUMP;
        o_job.count    = 2'd1;
        case (r_s1.op)
            lbph_pkg::OP_PUSH: begin
                o_job.valid = r_s1_valid && r_s1.win_ok;
                o_job.count = r_s1.nch;
                o_job.codes = codes;
            end
            lbph_pkg::OP_READ: begin
                o_job.valid    = r_s1_valid;
                o_job.kind     = lbph_pkg::JOB_READ;
                o_job.codes[0] = r_s1.bin;
            end
            lbph_pkg::OP_CLEAR: begin
                o_job.valid = r_s1_valid;
                o_job.kind  = lbph_pkg::JOB_CLEAR;
            end
            default: begin
                o_job.valid = 1'b0;
            end
        endcase
    end

    assign o_s1_busy = r_s1_valid;

endmodule
`default_nettype wire

// File: rtl/lbph_hist.sv
// Histogram memory with read-modify-write pipeline, clear and bin readout.
`timescale 1ns / 1ps
`default_nettype none
module lbph_hist #(
    parameter int COUNT_BITS = lbph_pkg::DEF_COUNT_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  lbph_pkg::t_job                        i_job,
    input  wire                                   i_out_stall,
    output lbph_pkg::t_hist_status                o_status,
    output logic                                  o_out_valid,
    output logic [lbph_pkg::CODE_BITS-1:0]        o_bin_index,
    output logic [lbph_pkg::OUT_COUNT_BITS-1:0]   o_bin_count
);

    localparam int BN   = lbph_pkg::BIN_NUM;
    localparam int CB   = lbph_pkg::CODE_BITS;
    localparam int OB   = lbph_pkg::OUT_COUNT_BITS;
    localparam int WIDE = (COUNT_BITS > OB) ? COUNT_BITS : OB;

    logic [COUNT_BITS-1:0] mem [BN];

    lbph_pkg::t_job        r_job;
    logic [1:0]            r_step;
    logic [COUNT_BITS-1:0] r_rdata;
    logic [BN-1:0]         r_ok;
    logic                  r_h1_valid;
    logic                  r_h1_read;
    logic [CB-1:0]         r_h1_bin;
    logic                  r_wr_valid;
    logic [CB-1:0]         r_wr_bin;
    logic [COUNT_BITS-1:0] r_wr_data;
    logic                  r_out_valid;
    logic [CB-1:0]         r_out_index;
    logic [OB-1:0]         r_out_count;

    logic                  issue;
    logic                  done_now;
    logic                  rd_issue;
    logic                  clr;
    logic                  h1_write;
    logic [CB-1:0]         cur_code;
    logic [COUNT_BITS-1:0] eff;
    logic [COUNT_BITS-1:0] inc;
    logic [WIDE-1:0]       eff_wide;
    logic [OB-1:0]         sat;

    assign cur_code = r_job.codes[r_step];

    // A read waits until the output register is sure to be free when its data lands.
    always_comb begin
        issue = r_job.valid;
        if (r_job.kind == lbph_pkg::JOB_READ) begin
            issue = r_job.valid && !(r_h1_valid && r_h1_read) &&
                    (!r_out_valid || !i_out_stall);
        end
        done_now = issue;
        if (r_job.kind == lbph_pkg::JOB_BUMP) begin
            done_now = issue && (r_step == r_job.count - 2'd1);
        end
    end

    assign rd_issue = issue && (r_job.kind != lbph_pkg::JOB_CLEAR);
    assign clr      = issue && (r_job.kind == lbph_pkg::JOB_CLEAR);
    assign h1_write = r_h1_valid && !r_h1_read;

    assign o_status.free_after = !r_job.valid || done_now ||
                                 ((r_job.kind == lbph_pkg::JOB_BUMP) &&
                                  (r_job.count - r_step == 2'd2));

    // Job register and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job  <= '0;
            r_step <= 2'd0;
        end else if (i_job.valid) begin
            r_job  <= i_job;
            r_step <= 2'd0;
        end else if (done_now) begin
            r_job.valid <= 1'b0;
        end else if (issue) begin
            r_step <= r_step + 2'd1;
        end
    end

    // Histogram memory: registered read, write-back from stage two.
    always_ff @(posedge i_clk) begin
        if (h1_write) begin
            mem[r_h1_bin] <= inc;
        end
        if (rd_issue) begin
            r_rdata <= mem[cur_code];
        end
    end

    // Stage two control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_valid <= 1'b0;
        end else begin
            r_h1_valid <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_h1_read <= (r_job.kind == lbph_pkg::JOB_READ);
            r_h1_bin  <= cur_code;
        end
    end

    // Forward the last write-back, which the memory read could not see yet.
    always_comb begin
        if (r_wr_valid && (r_wr_bin == r_h1_bin)) begin
            eff = r_wr_data;
        end else if (r_ok[r_h1_bin]) begin
            eff = r_rdata;
        end else begin
            eff = '0;
        end
        inc = (eff == {COUNT_BITS{1'b1}}) ? eff : eff + COUNT_BITS'(1);
        eff_wide = WIDE'(eff);
        sat = (eff_wide > WIDE'(lbph_pkg::OUT_COUNT_MAX)) ? lbph_pkg::OUT_COUNT_MAX :
              eff_wide[OB-1:0];
    end

    // Bin valid bits and forwarding flag; a clear drops both at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok       <= '0;
            r_wr_valid <= 1'b0;
        end else begin
            if (h1_write) begin
                r_ok[r_h1_bin] <= 1'b1;
            end
            r_wr_valid <= h1_write;
            if (clr) begin
                r_ok       <= '0;
                r_wr_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (h1_write) begin
            r_wr_bin  <= r_h1_bin;
            r_wr_data <= inc;
        end
    end

    // Output register for read results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_h1_valid && r_h1_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_h1_valid && r_h1_read) begin
            r_out_index <= r_h1_bin;
            r_out_count <= sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bin_index = r_out_index;
    assign o_bin_count = r_out_count;

endmodule
`default_nettype wire

// File: rtl/lbp_histogram_3x3_unit.sv
// Top level of the 3x3 local binary pattern histogram block.
// Pixels are pushed in raster order; each pixel with two rows and two columns behind it
// closes a 3x3 window and yields one 8-bit LBP code per counted channel, and each code
// bumps one saturating bin of a single 256-bin histogram held in a memory with one read and one write port.
// A push without a full window, a grey push or a clear word is taken every cycle unless a
// colour push or read ahead holds the input; a colour push holds it longer, since the
// histogram memory does one read-modify-write per cycle. A read result passes the window
// stage, job register and memory read to the output register, delayed by output stalls.
// Reset and the clear word empty the histogram at once through per-bin valid bits. APB
// writes set the registers at byte addresses 0 (width), 4 (height) and 8 (colour mode).
`timescale 1ns / 1ps
`default_nettype none
module lbp_histogram_3x3_unit #(
    parameter int MAX_WIDTH  = lbph_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lbph_pkg::DEF_MAX_HEIGHT,
    parameter int COUNT_BITS = lbph_pkg::DEF_COUNT_BITS,
    parameter int CHANNELS   = lbph_pkg::DEF_CHANNELS
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [lbph_pkg::ADDR_BITS-1:0]        paddr,
    input  wire [lbph_pkg::DATA_BITS-1:0]        pwdata,
    output logic [lbph_pkg::DATA_BITS-1:0]       prdata,
    output logic                                 pready,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire [1:0]                            i_op,
    input  wire [lbph_pkg::SAMPLE_BITS-1:0]      i_sample_first,
    input  wire [lbph_pkg::SAMPLE_BITS-1:0]      i_sample_second,
    input  wire [lbph_pkg::SAMPLE_BITS-1:0]      i_sample_third,
    input  wire [lbph_pkg::CODE_BITS-1:0]        i_bin_select,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic [lbph_pkg::CODE_BITS-1:0]       o_bin_index,
    output logic [lbph_pkg::OUT_COUNT_BITS-1:0]  o_bin_count
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EW  = ($clog2(MAX_WIDTH + 1) > lbph_pkg::FW_BITS) ?
                         $clog2(MAX_WIDTH + 1) : lbph_pkg::FW_BITS;
    localparam int EH  = ($clog2(MAX_HEIGHT + 1) > lbph_pkg::FH_BITS) ?
                         $clog2(MAX_HEIGHT + 1) : lbph_pkg::FH_BITS;
    localparam int SB  = lbph_pkg::SAMPLE_BITS;
    localparam int PW  = SB * CHANNELS;

    logic [lbph_pkg::FW_BITS-1:0] r_frame_width;
    logic [lbph_pkg::FH_BITS-1:0] r_frame_height;
    logic                         r_color_mode;
    logic [CW-1:0]                r_col;
    logic [RW-1:0]                r_row;
    logic [CW-1:0]                n_col;
    logic [RW-1:0]                n_row;

    logic                         cfg_wr;
    logic                         in_acc;
    logic [EW-1:0]                fw_ext;
    logic [EW-1:0]                eff_w;
    logic [EH-1:0]                fh_ext;
    logic [EH-1:0]                eff_h;
    logic [3*SB-1:0]              pix_full;
    logic                         s1_busy;
    logic                         s1_single;
    logic                         accept_ok;

    lbph_pkg::t_acc               acc;
    lbph_pkg::t_job               job;
    lbph_pkg::t_hist_status       hist_st;

    // Configuration registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= lbph_pkg::FW_RESET;
            r_frame_height <= lbph_pkg::FH_RESET;
            r_color_mode   <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                lbph_pkg::REG_WIDTH:  r_frame_width  <= pwdata[lbph_pkg::FW_BITS-1:0];
                lbph_pkg::REG_HEIGHT: r_frame_height <= pwdata[lbph_pkg::FH_BITS-1:0];
                lbph_pkg::REG_MODE:   r_color_mode   <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lbph_pkg::REG_WIDTH:  prdata = lbph_pkg::DATA_BITS'(r_frame_width);
            lbph_pkg::REG_HEIGHT: prdata = lbph_pkg::DATA_BITS'(r_frame_height);
            lbph_pkg::REG_MODE:   prdata = lbph_pkg::DATA_BITS'(r_color_mode);
            default:              prdata = '0;
        endcase
    end

    // Effective frame size, clamped to the supported range.
    always_comb begin
        fw_ext = EW'(r_frame_width);
        fh_ext = EH'(r_frame_height);
        if (fw_ext < EW'(lbph_pkg::MIN_SIZE)) begin
            eff_w = EW'(lbph_pkg::MIN_SIZE);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        if (fh_ext < EH'(lbph_pkg::MIN_SIZE)) begin
            eff_h = EH'(lbph_pkg::MIN_SIZE);
        end else if (fh_ext > EH'(MAX_HEIGHT)) begin
            eff_h = EH'(MAX_HEIGHT);
        end else begin
            eff_h = fh_ext;
        end
    end

    // Input flow control: the window stage and the job register must drain in time.
    assign s1_single = (job.kind == lbph_pkg::JOB_CLEAR) ||
                       ((job.kind == lbph_pkg::JOB_BUMP) && (job.count == 2'd1));

    always_comb begin
        if (s1_busy && job.valid) begin
            accept_ok = s1_single;
        end else begin
            accept_ok = hist_st.free_after;
        end
    end

    assign o_in_stall = !accept_ok;
    assign in_acc     = i_in_valid && accept_ok;

    // Accepted word description for the window stage.
    assign pix_full = {i_sample_third, i_sample_second, i_sample_first};

    always_comb begin
        acc.valid  = in_acc && ((i_op == lbph_pkg::OP_PUSH) || (i_op == lbph_pkg::OP_READ) ||
                                (i_op == lbph_pkg::OP_CLEAR));
        acc.op     = i_op;
        acc.win_ok = (r_row >= RW'(2)) && (r_col >= CW'(2));
        acc.nch    = r_color_mode ? 2'(CHANNELS) : 2'd1;
        acc.bin    = i_bin_select;
    end

    // Raster position of the next pushed pixel.
    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (EW'(r_col) + EW'(1) >= eff_w) begin
            n_col = '0;
            if (EH'(r_row) + EH'(1) >= eff_h) begin
                n_row = '0;
            end else begin
                n_row = r_row + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc && (i_op == lbph_pkg::OP_CLEAR)) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc && (i_op == lbph_pkg::OP_PUSH)) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    lbph_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .CHANNELS  (CHANNELS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_acc_col (r_col),
        .i_acc_pix (pix_full[PW-1:0]),
        .o_job     (job),
        .o_s1_busy (s1_busy)
    );

    lbph_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job),
        .i_out_stall (i_out_stall),
        .o_status    (hist_st),
        .o_out_valid (o_out_valid),
        .o_bin_index (o_bin_index),
        .o_bin_count (o_bin_count)
    );

endmodule
`default_nettype wire

// File: rtl/lbph_checker.sv
// Port-level assertions for the LBP histogram block and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lbph_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 psel,
    input wire                                 penable,
    input wire                                 pwrite,
    input wire [lbph_pkg::ADDR_BITS-1:0]       paddr,
    input wire [lbph_pkg::DATA_BITS-1:0]       pwdata,
    input wire [lbph_pkg::DATA_BITS-1:0]       prdata,
    input wire                                 pready,
    input wire                                 o_in_stall,
    input wire                                 o_out_valid,
    input wire                                 i_out_stall,
    input wire [lbph_pkg::CODE_BITS-1:0]       o_bin_index,
    input wire [lbph_pkg::OUT_COUNT_BITS-1:0]  o_bin_count
);

    // A stalled result word stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
        o_out_valid && $stable(o_bin_index) && $stable(o_bin_count))
        else $error("result word changed while stalled");

    // The register port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready dropped");

    // Reset leaves no result pending.
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // Reset leaves the block ready for a word.
    a_reset_stall: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled right after reset");

    // A width write reads back on the next cycle.
    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[3:2] == lbph_pkg::REG_WIDTH) |=>
        (paddr[3:2] != lbph_pkg::REG_WIDTH) ||
        (prdata[lbph_pkg::FW_BITS-1:0] == $past(pwdata[lbph_pkg::FW_BITS-1:0])))
        else $error("frame width readback mismatch");

endmodule

bind lbp_histogram_3x3_unit lbph_checker u_lbph_checker (.*);
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the 3x3 LBP histogram block: directed table, then random frames.
`timescale 1ns / 1ps
module tb_top;
    import lbph_pkg::*;

    localparam int LINE_LEN    = DEF_MAX_WIDTH;
    localparam int ROWS_MAX    = DEF_MAX_HEIGHT;
    localparam int CHAN_NUM    = DEF_CHANNELS;
    localparam int IDLE_CYCLES = 16;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [CODE_BITS-1:0]      idx;
        logic [OUT_COUNT_BITS-1:0] cnt;
    } bin_rd_t;

    typedef struct packed {
        logic [1:0]                op;
        logic [7:0]                s0;
        logic [7:0]                s1;
        logic [7:0]                s2;
        logic [7:0]                sel;
        bit                        typed;
        logic [OUT_COUNT_BITS-1:0] cnt;
    } dir_row_t;

    // Clock, reset and every block input start at known values.
    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      psel            = 1'b0;
    logic                      penable         = 1'b0;
    logic                      pwrite          = 1'b0;
    logic [ADDR_BITS-1:0]      paddr           = '0;
    logic [DATA_BITS-1:0]      pwdata          = '0;
    logic [DATA_BITS-1:0]      prdata;
    logic                      pready;
    logic                      i_in_valid      = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_op            = OP_PUSH;
    logic [SAMPLE_BITS-1:0]    i_sample_first  = '0;
    logic [SAMPLE_BITS-1:0]    i_sample_second = '0;
    logic [SAMPLE_BITS-1:0]    i_sample_third  = '0;
    logic [CODE_BITS-1:0]      i_bin_select    = '0;
    logic                      o_out_valid;
    logic                      i_out_stall     = 1'b0;
    logic [CODE_BITS-1:0]      o_bin_index;
    logic [OUT_COUNT_BITS-1:0] o_bin_count;

    // Shadow copy of the block state used for prediction.
    logic [23:0]               near_line [LINE_LEN];
    logic [23:0]               far_line [LINE_LEN];
    logic [23:0]               win_regs [6];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [OUT_COUNT_BITS-1:0] bin_counts [BIN_NUM];
    logic [FW_BITS-1:0]        cfg_width;
    logic [FH_BITS-1:0]        cfg_height;
    logic                      cfg_colour;
    logic [CODE_BITS-1:0]      recent_code;

    bin_rd_t     bin_reads_due [$];
    dir_row_t    dir_rows [$];
    int          err_count      = 0;
    int          burst_left     = 0;
    bit          gaps_on        = 1'b1;
    bit          hold_for_drain = 1'b0;
    int unsigned stall_ctr      = 0;
    logic [1:0]  stall_mode     = 2'd0;

    lbp_histogram_3x3_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_sample_first  (i_sample_first),
        .i_sample_second (i_sample_second),
        .i_sample_third  (i_sample_third),
        .i_bin_select    (i_bin_select),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_bin_index     (o_bin_index),
        .o_bin_count     (o_bin_count)
    );

    always #5 i_clk = ~i_clk;

    // Hard limit on the run time.
    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Output stall pattern: modes of random length, including stretches without stalls.
    always @(posedge i_clk) begin
        if (stall_ctr == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_ctr  <= $urandom_range(20, 120);
        end else begin
            stall_ctr <= stall_ctr - 1;
        end
        case (stall_mode)
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= stall_ctr[3];
        endcase
    end

    // Compare every accepted result word with the oldest pending bin read.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (bin_reads_due.size() == 0) begin
                $display("%0t: result with nothing expected, bin_index %0d bin_count %0d",
                         $time, o_bin_index, o_bin_count);
                err_count++;
            end else begin
                if (o_bin_index !== bin_reads_due[0].idx) begin
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, bin_reads_due[0].idx, o_bin_index);
                    err_count++;
                end
                if (o_bin_count !== bin_reads_due[0].cnt) begin
                    $display("%0t: bin_count of bin %0d expected %0d actual %0d",
                             $time, bin_reads_due[0].idx, bin_reads_due[0].cnt, o_bin_count);
                    err_count++;
                end
                void'(bin_reads_due.pop_front());
            end
        end
    end

    function automatic int clamp_size(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // One LBP code: neighbors compared against the center, first neighbor in the MSB.
    function automatic logic [7:0] lbp_code(input logic [7:0][23:0] nb, input logic [23:0] ctr,
                                            input int ch);
        logic [7:0] code;
        code = '0;
        for (int i = 0; i < 8; i++) begin
            code = {code[6:0], (nb[i][8*ch +: 8] > ctr[8*ch +: 8])};
        end
        return code;
    endfunction

    // Advance the shadow state by one accepted word; a read yields the expected bin word.
    task automatic apply_word(input logic [1:0] op, input logic [7:0] s0, input logic [7:0] s1,
                              input logic [7:0] s2, input logic [7:0] sel,
                              output bit got, output bin_rd_t rd);
        logic [23:0]      pix;
        logic [23:0]      top;
        logic [23:0]      mid;
        logic [7:0][23:0] nb;
        logic [7:0]       code;
        int unsigned      c;
        int               nch;
        got = 1'b0;
        rd  = '0;
        case (op)
            OP_READ: begin
                got    = 1'b1;
                rd.idx = sel;
                rd.cnt = bin_counts[sel];
            end
            OP_CLEAR: begin
                foreach (bin_counts[b]) bin_counts[b] = '0;
                col_pos = 0;
                row_pos = 0;
            end
            OP_PUSH: begin
                c   = col_pos % LINE_LEN;
                pix = {s2, s1, s0};
                top = far_line[c];
                mid = near_line[c];
                // A full window exists once two rows and two columns lie behind the pixel.
                if (row_pos >= 2 && c >= 2) begin
                    nb[0] = win_regs[0];
                    nb[1] = win_regs[1];
                    nb[2] = win_regs[2];
                    nb[3] = win_regs[3];
                    nb[4] = win_regs[5];
                    nb[5] = top;
                    nb[6] = mid;
                    nb[7] = pix;
                    nch   = cfg_colour ? CHAN_NUM : 1;
                    for (int ch = 0; ch < nch; ch++) begin
                        code = lbp_code(nb, win_regs[4], ch);
                        if (bin_counts[code] != OUT_COUNT_MAX)
                            bin_counts[code] = bin_counts[code] + 1'b1;
                        recent_code = code;
                    end
                end
                win_regs[0]  = win_regs[3];
                win_regs[1]  = win_regs[4];
                win_regs[2]  = win_regs[5];
                win_regs[3]  = top;
                win_regs[4]  = mid;
                win_regs[5]  = pix;
                far_line[c]  = mid;
                near_line[c] = pix;
                // Positions wrap against the clamped frame size.
                if (c + 1 >= clamp_size(int'(cfg_width), MIN_SIZE, LINE_LEN)) begin
                    col_pos = 0;
                    if (row_pos + 1 >= clamp_size(int'(cfg_height), MIN_SIZE, ROWS_MAX))
                        row_pos = 0;
                    else
                        row_pos = row_pos + 1;
                end else begin
                    col_pos = c + 1;
                end
            end
            default: ;
        endcase
    endtask

    // Drive one word in bursts with random gaps and record its expected result on acceptance.
    task automatic send_word(input logic [1:0] op, input logic [7:0] s0, input logic [7:0] s1,
                             input logic [7:0] s2, input logic [7:0] sel,
                             input bit typed, input logic [OUT_COUNT_BITS-1:0] typed_cnt);
        int      gap;
        bit      got;
        bin_rd_t rd;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 6);
        end
        burst_left--;
        if (hold_for_drain && gap == 0) gap = 1;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            while (hold_for_drain && bin_reads_due.size() != 0) @(posedge i_clk);
            hold_for_drain = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= op;
        i_sample_first  <= s0;
        i_sample_second <= s1;
        i_sample_third  <= s2;
        i_bin_select    <= sel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_word(op, s0, s1, s2, sel, got, rd);
        if (got) begin
            if (typed) rd.cnt = typed_cnt;
            bin_reads_due.push_back(rd);
        end
    endtask

    // Lower valid, let every pending result arrive, then give the block time to finish.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (bin_reads_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle and access cycle, then the bus goes idle.
    task automatic apb_cycle(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                             output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] exp_val);
        logic [31:0] rdata;
        apb_cycle(1'b0, idx, '0, rdata);
        if (rdata !== exp_val) begin
            $display("%0t: register %0d expected %0h actual %0h", $time, idx, exp_val, rdata);
            err_count++;
        end
    endtask

    task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rdata;
        logic [31:0] stored;
        apb_cycle(1'b1, idx, value, rdata);
        case (idx)
            REG_WIDTH: begin
                cfg_width = value[FW_BITS-1:0];
                stored    = 32'(cfg_width);
            end
            REG_HEIGHT: begin
                cfg_height = value[FH_BITS-1:0];
                stored     = 32'(cfg_height);
            end
            default: begin
                cfg_colour = value[0];
                stored     = 32'(cfg_colour);
            end
        endcase
        check_reg(idx, stored);
    endtask

    task automatic add_row(input logic [1:0] op, input logic [7:0] s0, input logic [7:0] s1,
                           input logic [7:0] s2, input logic [7:0] sel, input bit typed,
                           input logic [OUT_COUNT_BITS-1:0] cnt);
        dir_row_t row;
        row.op    = op;
        row.s0    = s0;
        row.s1    = s1;
        row.s2    = s2;
        row.sel   = sel;
        row.typed = typed;
        row.cnt   = cnt;
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] rand_sample(input bit narrow);
        if (narrow) return 8'($urandom_range(126, 129));
        return 8'($urandom);
    endfunction

    // Reprogram the frame while idle, then stream random words.
    task automatic run_phase(input logic [FW_BITS-1:0] w_reg, input logic [FH_BITS-1:0] h_reg,
                             input bit colour, input int n_words, input int push_pct,
                             input bit gaps);
        int         done;
        int         r;
        int         r2;
        bit         narrow;
        logic [1:0] op;
        logic [7:0] sel;
        // A wider line mid-frame would read line entries never written: restart first.
        if (clamp_size(int'(w_reg), MIN_SIZE, LINE_LEN) >
                clamp_size(int'(cfg_width), MIN_SIZE, LINE_LEN) &&
                (col_pos != 0 || row_pos != 0))
            send_word(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      1'b0, '0);
        wait_idle();
        program_reg(REG_WIDTH, 32'(w_reg));
        program_reg(REG_HEIGHT, 32'(h_reg));
        program_reg(REG_MODE, 32'(colour));
        gaps_on = gaps;
        done    = 0;
        while (done < n_words) begin
            if (done == n_words / 2) hold_for_drain = 1'b1;
            r      = $urandom_range(0, 99);
            r2     = $urandom_range(0, 19);
            narrow = ($urandom_range(0, 3) == 0);
            if (r < push_pct) op = OP_PUSH;
            else if (r2 == 0) op = OP_CLEAR;
            else if (r2 == 1) op = OP_IGNORED;
            else op = OP_READ;
            // Reads favor the bin bumped last, so that nonzero counts are seen.
            r2 = $urandom_range(0, 9);
            if (r2 < 4) sel = recent_code;
            else if (r2 == 4) sel = 8'hFF;
            else if (r2 == 5) sel = 8'h00;
            else sel = 8'($urandom);
            send_word(op, rand_sample(narrow), rand_sample(narrow), rand_sample(narrow), sel,
                      1'b0, '0);
            if (op != OP_IGNORED) done++;
        end
    endtask

    // Main sequence.
    initial begin
        foreach (bin_counts[b]) bin_counts[b] = '0;
        foreach (near_line[i]) near_line[i] = '0;
        foreach (far_line[i]) far_line[i] = '0;
        foreach (win_regs[i]) win_regs[i] = '0;
        col_pos     = 0;
        row_pos     = 0;
        cfg_width   = FW_RESET;
        cfg_height  = FH_RESET;
        cfg_colour  = 1'b1;
        recent_code = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Register values after reset, then the smallest frame through clamped values.
        check_reg(REG_WIDTH, 32'(FW_RESET));
        check_reg(REG_HEIGHT, 32'(FH_RESET));
        check_reg(REG_MODE, 32'd1);
        program_reg(REG_WIDTH, 32'd0);
        program_reg(REG_HEIGHT, 32'd2);
        program_reg(REG_MODE, 32'd1);

        // Directed part: one 3x3 colour frame with one code per channel easy to read off.
        // Channel 0 has every neighbor above the center, channel 1 only the up-left one,
        // channel 2 only the down-right one; equal samples do not set a bit.
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'd0);
        add_row(OP_READ,  8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h81, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'h80, 8'h80, 8'h80, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_PUSH,  8'hFF, 8'h80, 8'h81, 8'h00, 1'b0, 24'd0);
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 24'd1);
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'h80, 1'b1, 24'd1);
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'h01, 1'b1, 24'd1);
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'd0);
        // An unused operation code changes nothing.
        add_row(OP_IGNORED, 8'hFF, 8'hFF, 8'hFF, 8'h80, 1'b0, 24'd0);
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'h80, 1'b1, 24'd1);
        // Clearing empties every bin.
        add_row(OP_CLEAR, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 24'd0);
        add_row(OP_READ,  8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 24'd0);
        foreach (dir_rows[i])
            send_word(dir_rows[i].op, dir_rows[i].s0, dir_rows[i].s1, dir_rows[i].s2,
                      dir_rows[i].sel, dir_rows[i].typed, dir_rows[i].cnt);

        // Random part: small frames mostly, one frame at the widest line, one at the
        // tallest height, and a width cut in the middle of a frame.
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: run_phase(11'd5, 13'd4, 1'b0, 120, 80, 1'b1);
                1: run_phase(11'd1, 13'd0, 1'b1, 120, 80, 1'b1);
                2: run_phase(11'd2047, 13'd3, 1'b1, 2150, 98, 1'b1);
                3: run_phase(11'd4, 13'd8191, 1'b0, 120, 80, 1'b0);
                4: run_phase(11'd3, 13'd3, 1'b1, 120, 75, 1'b1);
                default: run_phase(11'($urandom_range(2, 12)), 13'($urandom_range(2, 7)),
                                   1'($urandom_range(0, 1)), 120, 80, (ph % 3) != 0);
            endcase
        end

        wait_idle();
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
